[design/chacha_pkg.sv]
// shared types, constants and helper functions for the chacha stream cipher
// no dependencies; used by every module in this folder
package chacha_pkg;

	localparam int BLOCK_BYTES = 64;
	localparam int POS_W = $clog2(BLOCK_BYTES);
	localparam int CFG_IDX_W = 3;

	localparam logic [31:0] SIGMA0 = 32'h6170_7865;
	localparam logic [31:0] SIGMA1 = 32'h3320_646E;
	localparam logic [31:0] SIGMA2 = 32'h7962_2D32;
	localparam logic [31:0] SIGMA3 = 32'h6B20_6574;

	localparam logic [CFG_IDX_W-1:0] REG_KEY_PART_0   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_PART_1   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_PART_2   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_PART_3   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NONCE_LOW    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_NONCE_HIGH   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_COUNTER = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_ROUNDS = 3'd7;

	localparam logic [3:0] DOUBLE_ROUNDS_RESET = 4'd10;

	typedef logic [31:0] word_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
	} out_item_t;

	typedef struct packed {
		logic [3:0][63:0] key_part;
		logic [63:0]      nonce_low;
		logic [31:0]      nonce_high;
		logic [31:0]      initial_counter;
		logic [3:0]       double_rounds;
	} cfg_t;

	typedef struct packed {
		logic start;
		logic shift;
	} core_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} core_sts_t;

	// initial state word for a given index
	function automatic word_t init_word(cfg_t cfg, word_t ctr, logic [3:0] idx);
		word_t w;
		case (idx)
			4'd0: w = SIGMA0;
			4'd1: w = SIGMA1;
			4'd2: w = SIGMA2;
			4'd3: w = SIGMA3;
			4'd4: w = cfg.key_part[0][31:0];
			4'd5: w = cfg.key_part[0][63:32];
			4'd6: w = cfg.key_part[1][31:0];
			4'd7: w = cfg.key_part[1][63:32];
			4'd8: w = cfg.key_part[2][31:0];
			4'd9: w = cfg.key_part[2][63:32];
			4'd10: w = cfg.key_part[3][31:0];
			4'd11: w = cfg.key_part[3][63:32];
			4'd12: w = ctr;
			4'd13: w = cfg.nonce_low[31:0];
			4'd14: w = cfg.nonce_low[63:32];
			default: w = cfg.nonce_high;
		endcase
		return w;
	endfunction

endpackage

[design/chacha_stream_cipher.sv]
// chacha stream cipher top level: configuration registers, byte channel, counter
// depends on chacha_pkg and chacha_core
//
//  channel   | signals                       | transfer when
//  ----------+-------------------------------+---------------------------
//  input     | in_valid in_stall in_data     | in_valid & !in_stall
//  output    | out_valid out_stall out_data  | out_valid & !out_stall
//  config    | cfg_we cfg_index cfg_data     | cfg_we
//
//  one byte per cycle while a block is held and the output is not stalled
//  a block is built by the single add/xor/rotate unit, one step per cycle
//  reset clears control state; the block for a byte at position 0 starts
//  only when that byte is offered; input stalls while no keystream block
//  is ready or the output register is full and stalled
module chacha_stream_cipher (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [chacha_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [63:0]                          cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  chacha_pkg::in_item_t                 in_data,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output chacha_pkg::out_item_t                out_data
);

	chacha_pkg::cfg_t      cfg_q;
	chacha_pkg::core_ctl_t ctl;
	chacha_pkg::core_sts_t sts;
	chacha_pkg::word_t     block_counter_q;
	logic [chacha_pkg::POS_W-1:0] pos_q;
	logic       msg_start_q;
	logic       ks_ready_q;
	logic       gen_q;
	logic       out_valid_q;
	chacha_pkg::out_item_t out_q;
	logic [7:0] ks_byte;
	logic       in_xfer;

	chacha_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.counter (block_counter_q),
		.ctl     (ctl),
		.sts     (sts),
		.ks_byte (ks_byte)
	);

	assign in_stall  = !ks_ready_q || (out_valid_q && out_stall);
	assign in_xfer   = in_valid && !in_stall;
	assign ctl.start = in_valid && !ks_ready_q && !gen_q && !sts.busy;
	assign ctl.shift = in_xfer;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.key_part        <= '0;
			cfg_q.nonce_low       <= '0;
			cfg_q.nonce_high      <= '0;
			cfg_q.initial_counter <= '0;
			cfg_q.double_rounds   <= chacha_pkg::DOUBLE_ROUNDS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				chacha_pkg::REG_KEY_PART_0:    cfg_q.key_part[0]     <= cfg_data;
				chacha_pkg::REG_KEY_PART_1:    cfg_q.key_part[1]     <= cfg_data;
				chacha_pkg::REG_KEY_PART_2:    cfg_q.key_part[2]     <= cfg_data;
				chacha_pkg::REG_KEY_PART_3:    cfg_q.key_part[3]     <= cfg_data;
				chacha_pkg::REG_NONCE_LOW:     cfg_q.nonce_low       <= cfg_data;
				chacha_pkg::REG_NONCE_HIGH:    cfg_q.nonce_high      <= cfg_data[31:0];
				chacha_pkg::REG_INIT_COUNTER:  cfg_q.initial_counter <= cfg_data[31:0];
				chacha_pkg::REG_DOUBLE_ROUNDS: cfg_q.double_rounds   <= cfg_data[3:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_counter_q <= '0;
			pos_q           <= '0;
			msg_start_q     <= 1'b1;
			ks_ready_q      <= 1'b0;
			gen_q           <= 1'b0;
			out_valid_q     <= 1'b0;
		end else begin
			if (ctl.start) begin
				gen_q       <= 1'b1;
				msg_start_q <= 1'b0;
				if (msg_start_q) begin
					block_counter_q <= cfg_q.initial_counter;
				end
			end
			if (sts.done) begin
				gen_q           <= 1'b0;
				ks_ready_q      <= 1'b1;
				block_counter_q <= block_counter_q + 32'd1;
			end
			if (in_xfer) begin
				out_valid_q <= 1'b1;
				if (in_data.in_last) begin
					pos_q       <= '0;
					msg_start_q <= 1'b1;
					ks_ready_q  <= 1'b0;
				end else begin
					pos_q <= pos_q + chacha_pkg::POS_W'(1);
					if (pos_q == chacha_pkg::POS_W'(chacha_pkg::BLOCK_BYTES - 1)) begin
						ks_ready_q <= 1'b0;
					end
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			out_q.out_byte <= in_data.in_byte ^ ks_byte;
			out_q.out_last <= in_data.in_last;
		end
	end

endmodule

[design/chacha_qr_unit.sv]
// shared add, xor and rotate unit: one quarter-round step per use
// depends on chacha_pkg
module chacha_qr_unit (
	input  chacha_pkg::word_t x,
	input  chacha_pkg::word_t y,
	input  chacha_pkg::word_t z,
	input  logic [1:0]        step,
	output chacha_pkg::word_t sum,
	output chacha_pkg::word_t mix
);

	chacha_pkg::word_t mixed;

	assign sum   = x + y;
	assign mixed = z ^ sum;

	always_comb begin
		case (step)
			2'd0: mix = {mixed[15:0], mixed[31:16]};
			2'd1: mix = {mixed[19:0], mixed[31:20]};
			2'd2: mix = {mixed[23:0], mixed[31:24]};
			default: mix = {mixed[24:0], mixed[31:25]};
		endcase
	end

endmodule

[design/chacha_core.sv]
// keystream block generator: 4x4 word array, round sequencer, final add
// depends on chacha_pkg and chacha_qr_unit
module chacha_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  chacha_pkg::cfg_t      cfg,
	input  chacha_pkg::word_t     counter,
	input  chacha_pkg::core_ctl_t ctl,
	output chacha_pkg::core_sts_t sts,
	output logic [7:0]            ks_byte
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_ROUND,
		ST_FINAL
	} state_t;

	state_t state_q;
	logic [1:0] step_q;
	logic [2:0] qr_q;
	logic [3:0] dr_q;
	logic [3:0] word_q;
	logic       done_q;
	logic [15:0][31:0] w_q;

	chacha_pkg::word_t op_x;
	chacha_pkg::word_t op_y;
	chacha_pkg::word_t op_z;
	chacha_pkg::word_t sum;
	chacha_pkg::word_t mix;
	logic [15:0][31:0] rnd;
	logic [15:0][31:0] rnd_rot;
	logic [1:0] amt;
	logic [1:0] col;

	chacha_qr_unit u_qr (
		.x    (op_x),
		.y    (op_y),
		.z    (op_z),
		.step (step_q),
		.sum  (sum),
		.mix  (mix)
	);

	always_comb begin
		if (state_q == ST_FINAL) begin
			op_x = w_q[0];
			op_y = chacha_pkg::init_word(cfg, counter, word_q);
			op_z = '0;
		end else if (!step_q[0]) begin
			op_x = w_q[0];
			op_y = w_q[4];
			op_z = w_q[12];
		end else begin
			op_x = w_q[8];
			op_y = w_q[12];
			op_z = w_q[4];
		end
	end

	// column 0 always holds the active quarter; rows rotate after each one
	always_comb begin
		amt = 2'd1;
		col = 2'd0;
		rnd = w_q;
		if (!step_q[0]) begin
			rnd[0]  = sum;
			rnd[12] = mix;
		end else begin
			rnd[8] = sum;
			rnd[4] = mix;
		end
		rnd_rot = rnd;
		for (int r = 0; r < 4; r++) begin
			if (qr_q == 3'd3) begin
				amt = 2'(r + 1);
			end else if (qr_q == 3'd7) begin
				amt = 2'(5 - r);
			end else begin
				amt = 2'd1;
			end
			for (int c = 0; c < 4; c++) begin
				col = 2'(c) + amt;
				rnd_rot[4 * r + c] = rnd[{2'(r), col}];
			end
		end
	end

	assign sts.busy = (state_q != ST_IDLE);
	assign sts.done = done_q;
	assign ks_byte  = w_q[0][7:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			qr_q    <= '0;
			dr_q    <= '0;
			word_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (ctl.start) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					step_q <= '0;
					qr_q   <= '0;
					dr_q   <= '0;
					word_q <= '0;
					if (cfg.double_rounds == 4'd0) begin
						state_q <= ST_FINAL;
					end else begin
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					step_q <= step_q + 2'd1;
					if (step_q == 2'd3) begin
						qr_q <= qr_q + 3'd1;
						if (qr_q == 3'd7) begin
							dr_q <= dr_q + 4'd1;
							if (dr_q + 4'd1 == cfg.double_rounds) begin
								state_q <= ST_FINAL;
							end
						end
					end
				end
				ST_FINAL: begin
					word_q <= word_q + 4'd1;
					if (word_q == 4'd15) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (ctl.shift) begin
					w_q <= w_q >> 8;
				end
			end
			ST_LOAD: begin
				for (int i = 0; i < 16; i++) begin
					w_q[i] <= chacha_pkg::init_word(cfg, counter, 4'(i));
				end
			end
			ST_ROUND: begin
				if (step_q == 2'd3) begin
					w_q <= rnd_rot;
				end else begin
					w_q <= rnd;
				end
			end
			ST_FINAL: begin
				w_q <= {sum, w_q[15:1]};
			end
			default: begin
				w_q <= w_q;
			end
		endcase
	end

endmodule
